// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, held off while reset is low
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check that also holds through reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: hw/rtl/imu_trs_pkg.sv
// types, constants and helpers for the imu tilt and rate status block
// used by imu_trs_ctrl, imu_trs_dp and the top level
`default_nettype none

package imu_trs_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned StatusW  = 7;
  localparam int unsigned PktW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned TanW     = 24;
  localparam int unsigned LimW     = 15;
  localparam int unsigned SqW      = 32;
  localparam int unsigned ProdW    = TanW + SqW;
  localparam int unsigned Q16Sh    = 16;

  localparam logic [TanW-1:0] RollTanRst  = 24'd14250;
  localparam logic [TanW-1:0] PitchTanRst = 24'd14250;
  localparam logic [LimW-1:0] RateXRst    = 15'd10000;
  localparam logic [LimW-1:0] RateYRst    = 15'd8571;

  // ready marks, one per sensor
  localparam logic [1:0] ReadyGyro  = 2'b01;
  localparam logic [1:0] ReadyAccel = 2'b10;
  localparam logic [1:0] ReadyBoth  = 2'b11;

  // status bit positions
  localparam int unsigned StRollRight = 0;
  localparam int unsigned StRollLeft  = 1;
  localparam int unsigned StRateXPos  = 2;
  localparam int unsigned StRateXNeg  = 3;
  localparam int unsigned StRateY     = 4;
  localparam int unsigned StPitchUp   = 5;
  localparam int unsigned StPitchDown = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROLL_TAN  = 3'd0,
    CFG_PITCH_TAN = 3'd1,
    CFG_RATE_X    = 3'd2,
    CFG_RATE_Y    = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_GYRO  = 1'b0,
    CMD_ACCEL = 1'b1
  } sample_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_ROLL,
    ST_PITCH,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_ROLL,
    OP_PITCH,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    logic              cmd;
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic signed [AxisW-1:0] axis_z;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status_bits;
    logic [PktW-1:0]    packet_number;
  } out_t;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // magnitude of a signed sample, -32768 maps to 32768
  function automatic logic [AxisW-1:0] abs16(input logic signed [AxisW-1:0] v);
    logic [AxisW-1:0] r;
    r = v[AxisW-1] ? AxisW'(-v) : AxisW'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imu_trs_ctrl.sv
// controller: ready marks and the sequence of datapath steps
// depends on imu_trs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module imu_trs_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_cmd_i,
  output logic                   in_ready_o,
  output imu_trs_pkg::dp_cmd_t   cmd_o,
  input  imu_trs_pkg::dp_sts_t   sts_i
);

  imu_trs_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]               marks_q, marks_d;
  logic [1:0]               marks_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imu_trs_pkg::ST_IDLE;
      marks_q <= '0;
    end else begin
      state_q <= state_d;
      marks_q <= marks_d;
    end
  end

  assign marks_new = marks_q | ((in_cmd_i == imu_trs_pkg::CMD_ACCEL) ?
                                imu_trs_pkg::ReadyAccel : imu_trs_pkg::ReadyGyro);

  always_comb begin
    state_d    = state_q;
    marks_d    = marks_q;
    in_ready_o = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.op   = imu_trs_pkg::OP_NONE;
    case (state_q)
      imu_trs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (marks_new == imu_trs_pkg::ReadyBoth) begin
            marks_d = '0;
            state_d = imu_trs_pkg::ST_SQX;
          end else begin
            marks_d = marks_new;
          end
        end
      end
      imu_trs_pkg::ST_SQX: begin
        cmd_o.op = imu_trs_pkg::OP_SQX;
        state_d  = imu_trs_pkg::ST_SQY;
      end
      imu_trs_pkg::ST_SQY: begin
        cmd_o.op = imu_trs_pkg::OP_SQY;
        state_d  = imu_trs_pkg::ST_SQZ;
      end
      imu_trs_pkg::ST_SQZ: begin
        cmd_o.op = imu_trs_pkg::OP_SQZ;
        state_d  = imu_trs_pkg::ST_ROLL;
      end
      imu_trs_pkg::ST_ROLL: begin
        cmd_o.op = imu_trs_pkg::OP_ROLL;
        state_d  = imu_trs_pkg::ST_PITCH;
      end
      imu_trs_pkg::ST_PITCH: begin
        cmd_o.op = imu_trs_pkg::OP_PITCH;
        state_d  = imu_trs_pkg::ST_FIN;
      end
      imu_trs_pkg::ST_FIN: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.op = imu_trs_pkg::OP_FIN;
          state_d  = imu_trs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = imu_trs_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_marks_never_both, marks_q != imu_trs_pkg::ReadyBoth, "both marks held")
  `ASSERT_CLK(a_pair_starts_work,
    (in_valid_i && in_ready_o && (marks_new == imu_trs_pkg::ReadyBoth)) |=>
    (state_q == imu_trs_pkg::ST_SQX && marks_q == 2'b00),
    "completed pair did not start the status sequence")
  `ASSERT_CLK(a_fin_needs_room,
    (state_q == imu_trs_pkg::ST_FIN && !sts_i.out_free) |=> (state_q == imu_trs_pkg::ST_FIN),
    "left finish step without room for the result")

endmodule

`default_nettype wire

// File: hw/rtl/imu_trs_dp.sv
// datapath: sample stores, config registers, shared multiplier, status and output register
// depends on imu_trs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module imu_trs_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  imu_trs_pkg::in_t                    in_data_i,
  input  imu_trs_pkg::dp_cmd_t                cmd_i,
  output imu_trs_pkg::dp_sts_t                sts_o,
  input  wire                                 cfg_valid_i,
  input  wire [imu_trs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire [imu_trs_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output imu_trs_pkg::out_t                   out_data_o
);

  localparam int unsigned AW = imu_trs_pkg::AxisW;
  localparam int unsigned PW = imu_trs_pkg::ProdW;
  localparam int unsigned SW = imu_trs_pkg::SqW;

  // sample stores, gyro z is never used by the status
  logic signed [AW-1:0] gyro_x_q, gyro_y_q;
  logic signed [AW-1:0] accel_x_q, accel_y_q, accel_z_q;

  logic [imu_trs_pkg::TanW-1:0] roll_tan_q, pitch_tan_q;
  logic [imu_trs_pkg::LimW-1:0] rate_x_lim_q, rate_y_lim_q;

  logic [SW-1:0] sx_q, sy_q, sz_q;
  logic [PW-1:0] prod_q;
  logic          roll_over_q;

  logic [imu_trs_pkg::TanW-1:0] mul_a;
  logic [SW-1:0]                mul_b;
  logic [PW-1:0]                mul_p;
  logic [AW-1:0]                ax_mag, ay_mag, az_mag, gx_mag, gy_mag;
  logic                         pitch_over;
  logic [imu_trs_pkg::StatusW-1:0] status;

  logic                         out_valid_q;
  imu_trs_pkg::out_t            out_q;
  logic [imu_trs_pkg::PktW-1:0] pkt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (in_data_i.cmd == imu_trs_pkg::CMD_ACCEL) begin
        accel_x_q <= in_data_i.axis_x;
        accel_y_q <= in_data_i.axis_y;
        accel_z_q <= in_data_i.axis_z;
      end else begin
        gyro_x_q <= in_data_i.axis_x;
        gyro_y_q <= in_data_i.axis_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_tan_q   <= imu_trs_pkg::RollTanRst;
      pitch_tan_q  <= imu_trs_pkg::PitchTanRst;
      rate_x_lim_q <= imu_trs_pkg::RateXRst;
      rate_y_lim_q <= imu_trs_pkg::RateYRst;
    end else if (cfg_valid_i) begin
      case (imu_trs_pkg::cfg_idx_e'(cfg_index_i))
        imu_trs_pkg::CFG_ROLL_TAN:  roll_tan_q   <= cfg_data_i[imu_trs_pkg::TanW-1:0];
        imu_trs_pkg::CFG_PITCH_TAN: pitch_tan_q  <= cfg_data_i[imu_trs_pkg::TanW-1:0];
        imu_trs_pkg::CFG_RATE_X:    rate_x_lim_q <= cfg_data_i[imu_trs_pkg::LimW-1:0];
        imu_trs_pkg::CFG_RATE_Y:    rate_y_lim_q <= cfg_data_i[imu_trs_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  assign ax_mag = imu_trs_pkg::abs16(accel_x_q);
  assign ay_mag = imu_trs_pkg::abs16(accel_y_q);
  assign az_mag = imu_trs_pkg::abs16(accel_z_q);
  assign gx_mag = imu_trs_pkg::abs16(gyro_x_q);
  assign gy_mag = imu_trs_pkg::abs16(gyro_y_q);

  // one shared multiplier: three squares, then the two tangent products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      imu_trs_pkg::OP_SQX: begin
        mul_a = imu_trs_pkg::TanW'(ax_mag);
        mul_b = SW'(ax_mag);
      end
      imu_trs_pkg::OP_SQY: begin
        mul_a = imu_trs_pkg::TanW'(ay_mag);
        mul_b = SW'(ay_mag);
      end
      imu_trs_pkg::OP_SQZ: begin
        mul_a = imu_trs_pkg::TanW'(az_mag);
        mul_b = SW'(az_mag);
      end
      imu_trs_pkg::OP_ROLL: begin
        // z square is still in the product register; sum is at most 2^31
        mul_a = roll_tan_q;
        mul_b = sx_q + prod_q[SW-1:0];
      end
      imu_trs_pkg::OP_PITCH: begin
        mul_a = pitch_tan_q;
        mul_b = sy_q + sz_q;
      end
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      imu_trs_pkg::OP_SQX: prod_q <= mul_p;
      imu_trs_pkg::OP_SQY: begin
        sx_q   <= prod_q[SW-1:0];
        prod_q <= mul_p;
      end
      imu_trs_pkg::OP_SQZ: begin
        sy_q   <= prod_q[SW-1:0];
        prod_q <= mul_p;
      end
      imu_trs_pkg::OP_ROLL: begin
        sz_q   <= prod_q[SW-1:0];
        prod_q <= mul_p;
      end
      imu_trs_pkg::OP_PITCH: begin
        roll_over_q <= PW'({sy_q, imu_trs_pkg::Q16Sh'(0)}) > prod_q;
        prod_q      <= mul_p;
      end
      default: ;
    endcase
  end

  assign pitch_over = PW'({sx_q, imu_trs_pkg::Q16Sh'(0)}) > prod_q;

  // aligned axes: roll uses -accel y, gyro x' is -raw y, gyro y' is -raw x
  always_comb begin
    status = '0;
    if (roll_over_q) begin
      if (accel_y_q[AW-1]) status[imu_trs_pkg::StRollRight] = 1'b1;
      else                 status[imu_trs_pkg::StRollLeft]  = 1'b1;
    end
    if (gy_mag > AW'(rate_x_lim_q)) begin
      if (gyro_y_q[AW-1]) status[imu_trs_pkg::StRateXPos] = 1'b1;
      else                status[imu_trs_pkg::StRateXNeg] = 1'b1;
    end
    if (gx_mag > AW'(rate_y_lim_q)) status[imu_trs_pkg::StRateY] = 1'b1;
    if (pitch_over) begin
      if (!accel_x_q[AW-1] && (accel_x_q != '0)) status[imu_trs_pkg::StPitchUp]   = 1'b1;
      else                                       status[imu_trs_pkg::StPitchDown] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pkt_q       <= '0;
    end else if (cmd_i.op == imu_trs_pkg::OP_FIN) begin
      out_valid_q <= 1'b1;
      pkt_q       <= pkt_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == imu_trs_pkg::OP_FIN) begin
      out_q.status_bits   <= status;
      out_q.packet_number <= pkt_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  `ASSERT_CLK(a_fin_fills_output, (cmd_i.op == imu_trs_pkg::OP_FIN) |=> out_valid_q,
    "finish step did not fill the output register")
  `ASSERT_CLK(a_pkt_advances,
    (cmd_i.op == imu_trs_pkg::OP_FIN) |=> (pkt_q == $past(pkt_q) + 1'b1),
    "packet counter did not advance on a result")
  `ASSERT_CLK(a_no_overwrite,
    (out_valid_q && !out_ready_i) |-> (cmd_i.op != imu_trs_pkg::OP_FIN),
    "pending result overwritten")

endmodule

`default_nettype wire

// File: hw/rtl/imu_tilt_and_rate_status_core.sv
// imu tilt and rate status block, top level
// instantiates imu_trs_ctrl and imu_trs_dp, types from imu_trs_pkg
//
// Samples enter on the in channel (valid/ready), tagged gyro or accel by cmd,
// and replace that sensor's stored sample. Once both sensors have reported,
// one status request leaves on the out channel: the 7-bit tilt and rate flags
// and the packet number, which starts at 0 and wraps at 65536.
// The cfg channel writes the two tangent-squared limits and the two gyro
// count limits; it is always ready and index values past the list are dropped.
// A sample that does not complete a pair only stores the sample and sets its mark. A sample that
// completes one is followed by five steps on the single shared 24x32
// multiplier (three squares, roll product, pitch product) plus a finish step,
// and in_ready is low until the finish step has put the result in the output
// register. A waiting result sits in that register while the next sample is
// taken; if the receiver stalls, the finish step waits for it.
// Reset clears the marks, the packet counter, the output valid and restores
// the limit registers to their defaults.
`default_nettype none

module imu_tilt_and_rate_status_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  imu_trs_pkg::in_t                    in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output imu_trs_pkg::out_t                   out_data_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [imu_trs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire [imu_trs_pkg::CfgDataW-1:0]     cfg_data_i
);

  imu_trs_pkg::dp_cmd_t dp_cmd;
  imu_trs_pkg::dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  imu_trs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  imu_trs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
